>>> rtl/pshash_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshash_pkg
// Types and constants shared by the point-set sequence hash.
// ----------------------------------------------------------------------------
package pshash_pkg;

   localparam int MAX_POINTS = 4096;
   localparam int POS_W      = $clog2(MAX_POINTS + 1);
   localparam int COUNT_W    = 13;
   localparam int COORD_W    = 8;
   localparam int HASH_W     = 64;
   localparam int HALF_W     = HASH_W / 2;

   localparam logic [HASH_W-1:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [HASH_W-1:0] MUL_A  = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [HASH_W-1:0] MUL_B  = 64'h94d0_49bb_1331_11eb;
   localparam int SHIFT_A = 30;
   localparam int SHIFT_B = 27;
   localparam int SHIFT_C = 31;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_POINT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_MUL_A,
      ST_MUL_B,
      ST_EMIT
   } state_type;

   // partial products of the low 64 bits of a 64x64 product
   typedef enum logic [1:0] {
      PH_LL,
      PH_LH,
      PH_HL
   } phase_type;

   typedef struct packed {
      logic en;
      logic first;
   } mac_ctl_type;

endpackage

>>> rtl/pshash_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshash_mac
// Shared 32x32 multiplier with a 64-bit accumulator. The first step loads
// the full product, later steps add the low product half into the upper word.
// ----------------------------------------------------------------------------
module pshash_mac
   import pshash_pkg::*;
(
   input  logic              clock,
   input  logic [HALF_W-1:0] op_a,
   input  logic [HALF_W-1:0] op_b,
   input  mac_ctl_type       ctl,
   output logic [HASH_W-1:0] sum
);

   logic [HASH_W-1:0] acc_ff;
   logic [HASH_W-1:0] prod;

   assign prod = HASH_W'(op_a) * HASH_W'(op_b);
   assign sum  = ctl.first ? prod : acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= sum;
      end
   end

endmodule

>>> rtl/point_set_sequence_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_sequence_hash
// Running splitmix64-finalizer hash over a stream of grid points.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  req     | req_valid / req_stall, cmd..is_last | in (item)
//  rsp     | rsp_valid / rsp_stall, hash_value   | out (item)
//
// Each item runs accept, golden add, then two 64-bit multiplies on the one
// shared 32x32 multiplier. After a last point, the hash moves into the output
// register in an emit state, which waits while the output is stalled.
// req_stall is high while an item is in work. Reset is synchronous; it sets
// the hash to zero and the position to one.
// ----------------------------------------------------------------------------
module point_set_sequence_hash
   import pshash_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_cmd,
   input  logic [COUNT_W-1:0]       req_point_count,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic                     req_is_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [HASH_W-1:0]        rsp_hash_value
);

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [HASH_W-1:0] val_ff, val_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0] rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              mul_done;
   logic              out_free;
   logic [HASH_W-1:0] base;
   logic [HASH_W-1:0] gold_sum;
   logic [HASH_W-1:0] mul_const;
   logic [HALF_W-1:0] mac_a;
   logic [HALF_W-1:0] mac_b;
   logic [HASH_W-1:0] mac_sum;
   mac_ctl_type       mac_ctl;

   pshash_mac u_mac (
      .clock (clock),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .ctl   (mac_ctl),
      .sum   (mac_sum)
   );

   assign accept   = req_valid && !req_stall;
   assign mul_done = (phase_ff == PH_HL);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_ADD;
         ST_ADD:   state_in = ST_MUL_A;
         ST_MUL_A: if (mul_done) state_in = ST_MUL_B;
         ST_MUL_B: if (mul_done) state_in = last_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall     = 1'b1;
      mac_ctl.en    = 1'b0;
      mac_ctl.first = (phase_ff == PH_LL);
      mul_const     = MUL_A;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_MUL_A: mac_ctl.en = 1'b1;
         ST_MUL_B: begin
            mac_ctl.en = 1'b1;
            mul_const  = MUL_B;
         end
         default:  req_stall = 1'b1;
      endcase
   end

   assign mac_a = (phase_ff == PH_HL) ? val_ff[HASH_W-1:HALF_W] : val_ff[HALF_W-1:0];
   assign mac_b = (phase_ff == PH_LH) ? mul_const[HASH_W-1:HALF_W] : mul_const[HALF_W-1:0];

   assign base = (req_cmd == CMD_START)
               ? HASH_W'(req_point_count)
               : hash_ff + HASH_W'({req_coord_x, req_coord_y}) + HASH_W'(pos_ff);
   assign gold_sum = val_ff + GOLDEN;

   // datapath
   always_comb begin
      val_in       = val_ff;
      hash_in      = hash_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      phase_in     = PH_LL;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (mac_ctl.en) begin
         case (phase_ff)
            PH_LL:   phase_in = PH_LH;
            PH_LH:   phase_in = PH_HL;
            default: phase_in = PH_LL;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in  = base;
               last_in = (req_cmd == CMD_POINT) && req_is_last;
               pos_in  = (req_cmd == CMD_START) ? POS_W'(1) : pos_ff + POS_W'(1);
            end
         end
         ST_ADD:   val_in = gold_sum ^ (gold_sum >> SHIFT_A);
         ST_MUL_A: if (mul_done) val_in = mac_sum ^ (mac_sum >> SHIFT_B);
         ST_MUL_B: if (mul_done) hash_in = mac_sum ^ (mac_sum >> SHIFT_C);
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hash_ff;
            end
         end
         default: val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LL;
         hash_ff      <= '0;
         pos_ff       <= POS_W'(1);
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         hash_ff      <= hash_in;
         pos_ff       <= pos_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_data_ff;

endmodule

>>> rtl/pshash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshash_checker
// Port-level checks for the point-set sequence hash, bound to the top level.
// ----------------------------------------------------------------------------
module pshash_checker
   import pshash_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [HASH_W-1:0] rsp_hash_value
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))
      else $error("stalled result item changed");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall ##1 req_stall ##1 req_stall ##1 req_stall
                   ##1 req_stall ##1 req_stall ##1 req_stall)
      else $error("input taken before hash rounds finished");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item appeared without an item in work");

   a_no_rsp_early: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result item appeared too soon after input");

endmodule

bind point_set_sequence_hash pshash_checker u_pshash_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hash_value (rsp_hash_value)
);

>>> tb/tb_point_set_sequence_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_set_sequence_hash
// Self-checking bench for the point-set sequence hash. A directed table covers
// coordinate and count extremes, a point stream without a start, a start with
// is_last set, points after the last one and count mismatch.
// Random well-formed point streams and noise follow, under four idle/stall
// mixes. Every item is run through an internal hash predictor, and each
// emitted hash is compared against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_point_set_sequence_hash
   import pshash_pkg::*;
();

   typedef struct packed {
      logic               cmd;
      logic [COUNT_W-1:0] count;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } point_item_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_cmd;
   logic [COUNT_W-1:0]        req_point_count;
   logic signed [COORD_W-1:0] req_coord_x;
   logic signed [COORD_W-1:0] req_coord_y;
   logic                      req_is_last;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [HASH_W-1:0]         rsp_hash_value;

   logic [HASH_W-1:0]  hash_state;
   logic [12:0]        pos_state;
   logic [HASH_W-1:0]  hash_q [$];
   int                 err_count;
   int                 idle_pct;
   int                 stall_pct;

   point_item_type dir_tab [0:13] = '{
      '{CMD_POINT, 13'd0,    8'h00, 8'h00, 1'b1},  // no start after reset
      '{CMD_START, 13'd0,    8'hff, 8'hff, 1'b1},  // is_last ignored on start
      '{CMD_POINT, 13'd0,    8'h80, 8'h7f, 1'b0},
      '{CMD_POINT, 13'd0,    8'h7f, 8'h80, 1'b0},
      '{CMD_POINT, 13'd0,    8'hff, 8'hff, 1'b0},
      '{CMD_POINT, 13'd0,    8'h00, 8'h00, 1'b1},
      '{CMD_POINT, 13'd0,    8'h55, 8'haa, 1'b1},  // chains past last
      '{CMD_START, 13'd4096, 8'h00, 8'h00, 1'b0},
      '{CMD_POINT, 13'd0,    8'h01, 8'h02, 1'b0},
      '{CMD_POINT, 13'd0,    8'haa, 8'h55, 1'b1},  // fewer points than count
      '{CMD_START, 13'd4095, 8'h12, 8'h34, 1'b0},
      '{CMD_POINT, 13'd8191, 8'hff, 8'h00, 1'b1},
      '{CMD_START, 13'd0,    8'h00, 8'h00, 1'b0},
      '{CMD_POINT, 13'd0,    8'h00, 8'hff, 1'b1}
   };

   point_set_sequence_hash uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_point_count (req_point_count),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hash_value  (rsp_hash_value)
   );

   always #1 clock = ~clock;

   function automatic logic [HASH_W-1:0] splitmix_final(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      t = v + GOLDEN;
      t = (t ^ (t >> SHIFT_A)) * MUL_A;
      t = (t ^ (t >> SHIFT_B)) * MUL_B;
      return t ^ (t >> SHIFT_C);
   endfunction

   // predictor: one accepted item
   task automatic advance_hash(input point_item_type it);
      logic [HASH_W-1:0] packed_xy;
      if (it.cmd == CMD_START) begin
         hash_state = splitmix_final({{(HASH_W-COUNT_W){1'b0}}, it.count});
         pos_state  = 13'd1;
      end else begin
         packed_xy  = {{(HASH_W-16){1'b0}}, it.x, it.y};
         hash_state = splitmix_final(hash_state + packed_xy + {51'd0, pos_state});
         pos_state  = pos_state + 13'd1;
         if (it.last)
            hash_q = {hash_q, hash_state};
      end
   endtask

   task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                  input logic [HASH_W-1:0] want);
      $display("MISMATCH %s: got %h want %h at %0t ns", what, got, want, $time);
      err_count++;
   endtask

   task automatic send_item(input point_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= it.cmd;
      req_point_count <= it.count;
      req_coord_x     <= it.x;
      req_coord_y     <= it.y;
      req_is_last     <= it.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_hash(it);
   endtask

   function automatic point_item_type rand_point(input logic last);
      point_item_type it;
      it.cmd   = CMD_POINT;
      it.count = 13'($urandom_range(8191));
      it.x     = 8'($urandom_range(255));
      it.y     = 8'($urandom_range(255));
      it.last  = last;
      return it;
   endfunction

   function automatic point_item_type rand_start(input int cnt);
      point_item_type it;
      it.cmd   = CMD_START;
      it.count = 13'(cnt);
      it.x     = 8'($urandom_range(255));
      it.y     = 8'($urandom_range(255));
      it.last  = 1'($urandom_range(1));
      return it;
   endfunction

   task automatic run_random(input int n_items);
      int sent;
      int len;
      int pick;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            send_item(rand_start(($urandom_range(3) == 0) ? $urandom_range(4096) : len));
            for (int i = 0; i < len; i++)
               send_item(rand_point(i == len - 1));
            sent += len + 1;
         end else if (pick < 88) begin
            send_item(rand_point($urandom_range(3) == 0));
            sent++;
         end else if (pick < 94) begin
            send_item(rand_start($urandom_range(4096)));
            sent++;
         end else begin
            // stream cut short by a new start
            len = $urandom_range(1, 5);
            send_item(rand_start($urandom_range(4096)));
            for (int i = 0; i < len; i++)
               send_item(rand_point(1'b0));
            sent += len + 1;
         end
      end
   endtask

   task automatic drain_hashes();
      @(negedge clock);
      req_valid <= 1'b0;
      while (hash_q.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin : rsp_check
      logic [HASH_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hash_q.size() == 0) begin
            report_mismatch("unexpected hash", rsp_hash_value, '0);
         end else begin
            want = hash_q.pop_front();
            if (rsp_hash_value !== want)
               report_mismatch("hash_value", rsp_hash_value, want);
         end
      end
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_START;
      req_point_count = '0;
      req_coord_x     = '0;
      req_coord_y     = '0;
      req_is_last     = 1'b0;
      rsp_stall       = 1'b0;
      idle_pct        = 0;
      stall_pct       = 0;
      err_count       = 0;
      hash_state      = '0;
      pos_state       = 13'd1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         send_item(dir_tab[i]);

      run_random(130);
      drain_hashes();
      idle_pct = 88;
      run_random(130);
      idle_pct  = 0;
      stall_pct = 88;
      run_random(130);
      idle_pct  = 33;
      stall_pct = 33;
      run_random(130);

      @(negedge clock);
      req_valid <= 1'b0;
      drain_hashes();
      repeat (30) @(posedge clock);
      if (hash_q.size() != 0)
         report_mismatch("hash never emitted", '0, hash_q[0]);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
rtl/pshash_pkg.sv
rtl/pshash_mac.sv
rtl/point_set_sequence_hash.sv
rtl/pshash_checker.sv
tb/tb_point_set_sequence_hash.sv
